// ===== design/rfcr_pkg.sv =====
// Package for the reference-first count reorder block.
// Holds count width, symbol codes and the decoded base type; no dependencies.
package rfcr_pkg;

    localparam int COUNT_BITS = 32;
    localparam int CNT_W      = COUNT_BITS - 1;
    localparam int NUM_BASES  = 4;
    localparam int NUM_ALTS   = NUM_BASES - 1;

    typedef logic [CNT_W-1:0] t_count;
    typedef logic [7:0]       t_symbol;
    typedef logic [1:0]       t_base_idx;

    localparam t_symbol SYM_A_UP = 8'h41;
    localparam t_symbol SYM_C_UP = 8'h43;
    localparam t_symbol SYM_G_UP = 8'h47;
    localparam t_symbol SYM_T_UP = 8'h54;
    localparam t_symbol SYM_N_UP = 8'h4E;
    localparam t_symbol SYM_A_LO = 8'h61;
    localparam t_symbol SYM_C_LO = 8'h63;
    localparam t_symbol SYM_G_LO = 8'h67;
    localparam t_symbol SYM_T_LO = 8'h74;
    localparam t_symbol SYM_N_LO = 8'h6E;

    typedef enum logic [2:0] {
        SEL_A,
        SEL_C,
        SEL_G,
        SEL_T,
        SEL_N,
        SEL_BAD
    } t_sel;

endpackage

// ===== design/rfcr_if.sv =====
// Valid/ready channel interfaces for the count reorder block.
// Depends on rfcr_pkg for the count and symbol types.
interface rfcr_in_if;
    logic             valid;
    logic             ready;
    rfcr_pkg::t_symbol ref_symbol;
    rfcr_pkg::t_count count_a;
    rfcr_pkg::t_count count_c;
    rfcr_pkg::t_count count_g;
    rfcr_pkg::t_count count_t;

    modport source (output valid, ref_symbol, count_a, count_c, count_g, count_t,
                    input ready);
    modport sink (input valid, ref_symbol, count_a, count_c, count_g, count_t,
                  output ready);
endinterface

interface rfcr_out_if;
    logic             valid;
    logic             ready;
    rfcr_pkg::t_count ref_count;
    rfcr_pkg::t_count alt_first;
    rfcr_pkg::t_count alt_second;
    rfcr_pkg::t_count alt_third;
    logic             bad_reference;

    modport source (output valid, ref_count, alt_first, alt_second, alt_third,
                    bad_reference, input ready);
    modport sink (input valid, ref_count, alt_first, alt_second, alt_third,
                  bad_reference, output ready);
endinterface

// ===== design/reference_first_count_reorder_top.sv =====
// Top level of the reference-first count reorder block.
// Depends on rfcr_pkg and the channel interfaces in rfcr_if.sv.
//
// Usage:
//   i_item carries one position per transaction: the reference symbol (ASCII
//   A/C/G/T/N, either case) and the four base counts. o_result carries one
//   transaction per input: the reference count first, then the other three
//   counts from largest to smallest, plus bad_reference. For N the base with
//   the highest count is the reference, the first of equal counts winning.
//   An unknown symbol sets bad_reference and passes the counts unchanged.
//   Pipeline: an accepted transaction passes the input register, one
//   compare-and-select level and the result register; a stall on o_result
//   can hold it in either register before the result transaction completes.
//   Throughput: one transaction per cycle while o_result.ready stays high;
//   all pairwise count compares run in parallel, so nothing iterates.
//   Reset: synchronous, active low; empties both register stages.
//   Stall: while o_result.ready is low the result holds, the input register
//   still fills, and i_item.ready drops only once both stages are full.
module reference_first_count_reorder_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rfcr_in_if.sink      i_item,
    rfcr_out_if.source   o_result
);

    logic              r_in_vld;
    rfcr_pkg::t_symbol r_in_sym;
    rfcr_pkg::t_count  r_in_cnt [rfcr_pkg::NUM_BASES];

    logic              r_out_vld;
    rfcr_pkg::t_count  r_out_ref;
    rfcr_pkg::t_count  r_out_alt [rfcr_pkg::NUM_ALTS];
    logic              r_out_bad;

    logic              out_free;
    logic              in_free;

    rfcr_pkg::t_sel      sel_code;
    logic [rfcr_pkg::NUM_BASES-1:0] gt [rfcr_pkg::NUM_BASES];
    logic [rfcr_pkg::NUM_BASES-1:0] max_hit;
    rfcr_pkg::t_base_idx ref_idx;
    logic [1:0]          rank [rfcr_pkg::NUM_BASES];
    logic [rfcr_pkg::NUM_BASES-1:0] slot_hit [rfcr_pkg::NUM_ALTS];

    rfcr_pkg::t_count  n_ref;
    rfcr_pkg::t_count  n_alt [rfcr_pkg::NUM_ALTS];
    logic              n_bad;

    assign out_free     = !r_out_vld || o_result.ready;
    assign in_free      = !r_in_vld || out_free;
    assign i_item.ready = in_free;

    always_comb begin
        unique case (r_in_sym)
            rfcr_pkg::SYM_A_UP, rfcr_pkg::SYM_A_LO: sel_code = rfcr_pkg::SEL_A;
            rfcr_pkg::SYM_C_UP, rfcr_pkg::SYM_C_LO: sel_code = rfcr_pkg::SEL_C;
            rfcr_pkg::SYM_G_UP, rfcr_pkg::SYM_G_LO: sel_code = rfcr_pkg::SEL_G;
            rfcr_pkg::SYM_T_UP, rfcr_pkg::SYM_T_LO: sel_code = rfcr_pkg::SEL_T;
            rfcr_pkg::SYM_N_UP, rfcr_pkg::SYM_N_LO: sel_code = rfcr_pkg::SEL_N;
            default:                                sel_code = rfcr_pkg::SEL_BAD;
        endcase
    end

    always_comb begin
        for (int i = 0; i < rfcr_pkg::NUM_BASES; i++) begin
            for (int j = 0; j < rfcr_pkg::NUM_BASES; j++) begin
                gt[i][j] = (i != j) && (r_in_cnt[i] > r_in_cnt[j]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < rfcr_pkg::NUM_BASES; i++) begin
            max_hit[i] = 1'b1;
            for (int j = 0; j < rfcr_pkg::NUM_BASES; j++) begin
                if (j < i && !gt[i][j]) begin
                    max_hit[i] = 1'b0;
                end
                if (j > i && gt[j][i]) begin
                    max_hit[i] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        unique case (sel_code)
            rfcr_pkg::SEL_A: ref_idx = 2'd0;
            rfcr_pkg::SEL_C: ref_idx = 2'd1;
            rfcr_pkg::SEL_G: ref_idx = 2'd2;
            rfcr_pkg::SEL_T: ref_idx = 2'd3;
            rfcr_pkg::SEL_N: begin
                priority if (max_hit[0]) ref_idx = 2'd0;
                else if (max_hit[1])     ref_idx = 2'd1;
                else if (max_hit[2])     ref_idx = 2'd2;
                else                     ref_idx = 2'd3;
            end
            default: ref_idx = 2'd0;
        endcase
    end

    // Rank each non-reference count; ties break toward the lower index.
    always_comb begin
        for (int i = 0; i < rfcr_pkg::NUM_BASES; i++) begin
            rank[i] = 2'd0;
            for (int j = 0; j < rfcr_pkg::NUM_BASES; j++) begin
                if (j != i && ref_idx != 2'(j)) begin
                    if (j < i) begin
                        rank[i] = rank[i] + 2'(!gt[i][j]);
                    end else begin
                        rank[i] = rank[i] + 2'(gt[j][i]);
                    end
                end
            end
        end
        for (int k = 0; k < rfcr_pkg::NUM_ALTS; k++) begin
            for (int i = 0; i < rfcr_pkg::NUM_BASES; i++) begin
                slot_hit[k][i] = (ref_idx != 2'(i)) && (rank[i] == 2'(k));
            end
        end
    end

    always_comb begin
        n_bad = (sel_code == rfcr_pkg::SEL_BAD);
        if (n_bad) begin
            n_ref = r_in_cnt[0];
            for (int k = 0; k < rfcr_pkg::NUM_ALTS; k++) begin
                n_alt[k] = r_in_cnt[k+1];
            end
        end else begin
            n_ref = r_in_cnt[ref_idx];
            for (int k = 0; k < rfcr_pkg::NUM_ALTS; k++) begin
                n_alt[k] = '0;
                for (int i = 0; i < rfcr_pkg::NUM_BASES; i++) begin
                    n_alt[k] = n_alt[k] | (slot_hit[k][i] ? r_in_cnt[i] : '0);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_free) begin
                r_in_vld <= i_item.valid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && in_free) begin
            r_in_sym    <= i_item.ref_symbol;
            r_in_cnt[0] <= i_item.count_a;
            r_in_cnt[1] <= i_item.count_c;
            r_in_cnt[2] <= i_item.count_g;
            r_in_cnt[3] <= i_item.count_t;
        end
        if (r_in_vld && out_free) begin
            r_out_ref <= n_ref;
            r_out_alt <= n_alt;
            r_out_bad <= n_bad;
        end
    end

    assign o_result.valid         = r_out_vld;
    assign o_result.ref_count     = r_out_ref;
    assign o_result.alt_first     = r_out_alt[0];
    assign o_result.alt_second    = r_out_alt[1];
    assign o_result.alt_third     = r_out_alt[2];
    assign o_result.bad_reference = r_out_bad;

    a_sorted_alts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.bad_reference) |->
            (o_result.alt_first >= o_result.alt_second &&
             o_result.alt_second >= o_result.alt_third))
        else $error("alternate counts out of order");

    a_slots_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !n_bad) |->
            ($onehot(slot_hit[0]) && $onehot(slot_hit[1]) && $onehot(slot_hit[2])))
        else $error("alternate slot not filled by exactly one count");

    a_single_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && sel_code == rfcr_pkg::SEL_N) |-> $onehot(max_hit))
        else $error("wildcard pick is not unique");

    a_bad_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && out_free) |=>
            (o_result.valid && o_result.bad_reference == $past(n_bad)))
        else $error("result did not advance with its error flag");

    a_input_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> r_in_vld)
        else $error("accepted transaction lost at input register");

endmodule
